>>> src/stfa_pkg.sv
// Shared types, constants and codes for the slot table first-fit allocator.
// Used by stfa_slot_store and slot_table_first_fit_allocator; no dependencies.
`default_nettype none

package stfa_pkg;

    localparam int VAR_SLOTS   = 32;
    localparam int TOTAL_SLOTS = 33;
    localparam int TEMP_FIRST  = 26;
    localparam int SLOT_W      = $clog2(TOTAL_SLOTS + 1);

    // request codes
    localparam logic [1:0] REQ_ALLOC = 2'd0;
    localparam logic [1:0] REQ_FREE  = 2'd1;
    localparam logic [1:0] REQ_LINE  = 2'd2;
    localparam logic [1:0] REQ_NONE  = 2'd3;

    // status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_NO_TEMP   = 2'd1;
    localparam logic [1:0] ST_NO_MEM    = 2'd2;
    localparam logic [1:0] ST_NOT_FREED = 2'd3;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [15:0]       alloc_words;
        logic              want_temp;
        logic [SLOT_W-1:0] slot_index;
        logic              has_pointer;
        logic [15:0]       free_offset;
    } in_t;

    typedef struct packed {
        logic [1:0]        status;
        logic [15:0]       block_offset_out;
        logic [SLOT_W-1:0] slot_used;
    } out_t;

    typedef struct packed {
        logic [15:0] off;
        logic [15:0] size;
    } slot_entry_t;

    // write command to the slot store
    typedef struct packed {
        logic              en;
        logic              off_en;
        logic [SLOT_W-1:0] addr;
        logic [15:0]       off;
        logic [15:0]       size;
    } slot_wr_t;

endpackage

`default_nettype wire

>>> src/slot_table_first_fit_allocator.sv
// Top level of the slot table first-fit allocator: request sequencer and
// output register. Depends on stfa_pkg and stfa_slot_store.
//
// Usage:
//   in channel  (in_valid/in_stall/in_data): one request per transfer.
//   out channel (out_valid/out_stall/out_data): exactly one result per request.
//   cfg channel (cfg_valid/cfg_ready/cfg_data): heap size in words, write only
//   while the block is idle; cfg_ready is always high.
// Timing: the slot table is a 33-entry memory read one entry per cycle, and a
//   small compare/add unit walks it under the sequencer. Line start sweeps the
//   temporary slots and free scans the table up to the matching slot; a no-op
//   request, null free or slot index out of range goes straight to the result.
//   Allocate looks for a free temporary slot if asked, then runs the tail pass
//   and, if the block does not fit there, the gap pass, which tries one slot
//   after another.
//   in_stall is high from the transfer until the result sits in the output
//   register, so one request is worked on at a time.
// Reset: every slot reads free with offset 0 (per-entry valid bits, no
//   clearing pass) and the heap size is 0. Output is empty after reset.
// Stall: while out_stall holds a result, the next request can still be taken
//   and processed; its result waits in the sequencer until the output frees.
`default_nettype none

module slot_table_first_fit_allocator (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire stfa_pkg::in_t in_data,
    output logic               out_valid,
    input  wire logic          out_stall,
    output stfa_pkg::out_t     out_data,
    input  wire logic          cfg_valid,
    output logic               cfg_ready,
    input  wire logic [15:0]   cfg_data
);

    localparam int SW = stfa_pkg::SLOT_W;
    localparam logic [SW-1:0] LAST_SLOT  = SW'(stfa_pkg::TOTAL_SLOTS - 1);
    localparam logic [SW-1:0] TEMP_LO    = SW'(stfa_pkg::TEMP_FIRST);
    localparam logic [SW-1:0] TEMP_HI    = SW'(stfa_pkg::VAR_SLOTS - 1);
    localparam logic [SW-1:0] NUM_SLOTS  = SW'(stfa_pkg::TOTAL_SLOTS);

    typedef enum logic [3:0] {
        S_IDLE,
        S_TEMP,     // look for a free temporary slot
        S_TAIL,     // find end of highest block
        S_TAILCHK,  // does the tail candidate fit
        S_GBASE,    // load base slot of the gap pass
        S_GLIM,     // nearest offset above base
        S_GFIT,     // candidate fits below limit
        S_GCLASH,   // overlap test against all slots
        S_WRITE,
        S_FREE,
        S_LINE,
        S_DONE
    } state_t;

    state_t          state_reg,  state_next;
    logic [SW-1:0]   idx_reg,    idx_next;     // entry being read this cycle
    logic [SW-1:0]   gi_reg,     gi_next;      // gap pass base slot
    logic [SW-1:0]   slot_reg,   slot_next;    // target slot
    logic [16:0]     cand_reg,   cand_next;
    logic [15:0]     base_reg,   base_next;
    logic [15:0]     limit_reg,  limit_next;
    logic [15:0]     need_reg,   need_next;
    logic [15:0]     foff_reg,   foff_next;
    logic [15:0]     heap_reg,   heap_next;
    stfa_pkg::out_t  res_reg,    res_next;
    logic            out_valid_reg, out_valid_next;
    stfa_pkg::out_t  out_data_reg,  out_data_next;

    stfa_pkg::slot_wr_t    wr;
    stfa_pkg::slot_entry_t ent;
    logic                  ent_valid;

    logic        in_xfer;
    logic        out_free;
    logic [16:0] ent_end;
    logic [17:0] cand_need;
    logic        clash;

    stfa_slot_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr       (wr),
        .rd_addr  (idx_next),
        .rd_entry (ent),
        .rd_valid (ent_valid)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign in_xfer   = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // shared arithmetic
    assign ent_end   = {1'b0, ent.off} + {1'b0, ent.size};
    assign cand_need = {1'b0, cand_reg} + {2'b0, need_reg};
    assign clash     = (cand_need >= {2'b0, ent.off}) && (ent_end > cand_reg);

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        gi_next        = gi_reg;
        slot_next      = slot_reg;
        cand_next      = cand_reg;
        base_next      = base_reg;
        limit_next     = limit_reg;
        need_next      = need_reg;
        foff_next      = foff_reg;
        heap_next      = cfg_valid ? cfg_data : heap_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        wr             = '0;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_xfer)
                begin
                    need_next = in_data.alloc_words;
                    foff_next = in_data.free_offset;
                    res_next  = '{status: stfa_pkg::ST_DONE, block_offset_out: 16'd0,
                                  slot_used: '0};
                    unique case (in_data.req_type)
                        stfa_pkg::REQ_ALLOC:
                        begin
                            cand_next = 17'd0;
                            if (in_data.want_temp)
                            begin
                                idx_next   = TEMP_LO;
                                state_next = S_TEMP;
                            end
                            else if (in_data.slot_index < NUM_SLOTS)
                            begin
                                slot_next  = in_data.slot_index;
                                idx_next   = '0;
                                state_next = S_TAIL;
                            end
                            else
                            begin
                                res_next.status = stfa_pkg::ST_NO_TEMP;
                                state_next      = S_DONE;
                            end
                        end
                        stfa_pkg::REQ_FREE:
                        begin
                            if (in_data.has_pointer)
                            begin
                                idx_next   = '0;
                                state_next = S_FREE;
                            end
                            else
                            begin
                                res_next.status = stfa_pkg::ST_NOT_FREED;
                                state_next      = S_DONE;
                            end
                        end
                        stfa_pkg::REQ_LINE:
                        begin
                            idx_next   = TEMP_LO;
                            state_next = S_LINE;
                        end
                        stfa_pkg::REQ_NONE:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_TEMP:
            begin
                if (ent.size == 16'd0)
                begin
                    slot_next  = idx_reg;
                    idx_next   = '0;
                    state_next = S_TAIL;
                end
                else if (idx_reg == TEMP_HI)
                begin
                    res_next.status = stfa_pkg::ST_NO_TEMP;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_TAIL:
            begin
                if ((ent.size != 16'd0) && (cand_reg <= {1'b0, ent.off}))
                begin
                    cand_next = ent_end;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_TAILCHK;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_TAILCHK:
            begin
                if (cand_need <= {2'b0, heap_reg})
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    gi_next    = '0;
                    idx_next   = '0;
                    state_next = S_GBASE;
                end
            end

            S_GBASE:
            begin
                base_next  = ent.off;
                cand_next  = ent_end;
                limit_next = heap_reg;
                idx_next   = '0;
                state_next = S_GLIM;
            end

            S_GLIM:
            begin
                if ((base_reg < ent.off) && (ent.off < limit_reg))
                begin
                    limit_next = ent.off;
                end
                if (idx_reg == LAST_SLOT)
                begin
                    idx_next   = '0;
                    state_next = S_GFIT;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_GFIT:
            begin
                if (cand_need <= {2'b0, limit_reg})
                begin
                    idx_next   = '0;
                    state_next = S_GCLASH;
                end
                else if (gi_reg == LAST_SLOT)
                begin
                    res_next.status = stfa_pkg::ST_NO_MEM;
                    state_next      = S_DONE;
                end
                else
                begin
                    gi_next    = gi_reg + 1'b1;
                    idx_next   = gi_reg + 1'b1;
                    state_next = S_GBASE;
                end
            end

            S_GCLASH:
            begin
                if (clash)
                begin
                    if (gi_reg == LAST_SLOT)
                    begin
                        res_next.status = stfa_pkg::ST_NO_MEM;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        gi_next    = gi_reg + 1'b1;
                        idx_next   = gi_reg + 1'b1;
                        state_next = S_GBASE;
                    end
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_WRITE:
            begin
                wr.en     = 1'b1;
                wr.off_en = 1'b1;
                wr.addr   = slot_reg;
                wr.off    = cand_reg[15:0];
                wr.size   = need_reg;
                res_next.status           = stfa_pkg::ST_DONE;
                res_next.block_offset_out = cand_reg[15:0];
                res_next.slot_used        = slot_reg;
                state_next                = S_DONE;
            end

            S_FREE:
            begin
                if (ent.off == foff_reg)
                begin
                    // never-written entries already read as free
                    wr.en           = ent_valid;
                    wr.addr         = idx_reg;
                    res_next.status = stfa_pkg::ST_DONE;
                    state_next      = S_DONE;
                end
                else if (idx_reg == LAST_SLOT)
                begin
                    res_next.status = stfa_pkg::ST_NOT_FREED;
                    state_next      = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_LINE:
            begin
                wr.en   = ent_valid;
                wr.addr = idx_reg;
                if (idx_reg == TEMP_HI)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = res_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            gi_reg        <= '0;
            slot_reg      <= '0;
            cand_reg      <= '0;
            base_reg      <= '0;
            limit_reg     <= '0;
            need_reg      <= '0;
            foff_reg      <= '0;
            heap_reg      <= '0;
            res_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_data_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            gi_reg        <= gi_next;
            slot_reg      <= slot_next;
            cand_reg      <= cand_next;
            base_reg      <= base_next;
            limit_reg     <= limit_next;
            need_reg      <= need_next;
            foff_reg      <= foff_next;
            heap_reg      <= heap_next;
            res_reg       <= res_next;
            out_valid_reg <= out_valid_next;
            out_data_reg  <= out_data_next;
        end
    end

    // the block is busy in the cycle after it accepts a request
    a_busy_after_xfer: assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer |=> in_stall)
        else $error("block idle right after input transfer");

    // a new result appears only out of the finishing state
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == S_DONE))
        else $error("result loaded outside finishing state");

    // table writes only come from the write, free and line-start steps
    a_write_states: assert property (@(posedge clk) disable iff (!rst_n)
        wr.en |-> (state_reg == S_WRITE || state_reg == S_FREE || state_reg == S_LINE))
        else $error("slot table written from wrong state");

    // line start sweeps only temporary slots
    a_line_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINE) |-> (idx_reg >= TEMP_LO && idx_reg <= TEMP_HI))
        else $error("line start outside temporary slots");

    // read address stays inside the table
    a_rd_range: assert property (@(posedge clk) disable iff (!rst_n)
        idx_next < NUM_SLOTS)
        else $error("slot read address out of range");

endmodule

`default_nettype wire

>>> src/stfa_slot_store.sv
// Slot table storage: offset and size memories with per-entry valid bits.
// Depends on stfa_pkg.
`default_nettype none

module stfa_slot_store (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire stfa_pkg::slot_wr_t       wr,
    input  wire logic [stfa_pkg::SLOT_W-1:0] rd_addr,
    output stfa_pkg::slot_entry_t         rd_entry,
    output logic                          rd_valid
);

    logic [15:0] off_mem  [stfa_pkg::TOTAL_SLOTS];
    logic [15:0] size_mem [stfa_pkg::TOTAL_SLOTS];
    logic [stfa_pkg::TOTAL_SLOTS-1:0] valid_reg;

    logic [15:0] rd_off_reg;
    logic [15:0] rd_size_reg;
    logic        rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            size_mem[wr.addr] <= wr.size;
            if (wr.off_en)
            begin
                off_mem[wr.addr] <= wr.off;
            end
        end
        rd_off_reg  <= off_mem[rd_addr];
        rd_size_reg <= size_mem[rd_addr];
    end

    // an entry reads as zero until an allocate has written it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr.en && wr.off_en)
            begin
                valid_reg[wr.addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_valid      = rd_valid_reg;
    assign rd_entry.off  = rd_valid_reg ? rd_off_reg  : 16'd0;
    assign rd_entry.size = rd_valid_reg ? rd_size_reg : 16'd0;

endmodule

`default_nettype wire

>>> verif/slot_table_first_fit_allocator_tb.sv
// Self-checking testbench for slot_table_first_fit_allocator.
// Depends on stfa_pkg and the allocator RTL; the slot table is mirrored in the
// testbench and every result transfer is checked against that mirror.
`default_nettype none

module slot_table_first_fit_allocator_tb;

    // No transfer of any kind for this many cycles means the block is hung.
    // The slowest allocate finishes well inside this limit, so it leaves a wide margin.
    localparam int HANG_LIMIT = 20000;
    // Items per random phase; six phases give about 500 random items.
    localparam int PHASE_ITEMS = 84;
    localparam int SW = stfa_pkg::SLOT_W;

    logic            clk;
    logic            rst_n;
    logic            in_valid;
    logic            in_stall;
    stfa_pkg::in_t   in_data;
    logic            out_valid;
    logic            out_stall;
    stfa_pkg::out_t  out_data;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [15:0]     cfg_data;

    slot_table_first_fit_allocator dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Mirror of the slot table and the heap size register.
    logic [15:0] shadow_off  [stfa_pkg::TOTAL_SLOTS];
    logic [15:0] shadow_size [stfa_pkg::TOTAL_SLOTS];
    logic [15:0] shadow_heap;

    stfa_pkg::in_t  pend_q[$];            // requests waiting to be driven
    stfa_pkg::out_t expected_results[$];  // predicted results, oldest first
    stfa_pkg::out_t due;
    logic in_xfer;              // request transfer happened at the last rising edge
    int   send_idle_pct;
    int   recv_idle_pct;
    int   error_count;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input int got_v, input int want_v);
        $display("ERROR at %0t: %s: got %0d, want %0d", $time, what, got_v, want_v);
        error_count++;
    endtask

    // Block placement: first the space after the highest block, then first fit
    // after the end of each slot (free slots included), with the bounds and
    // overlap tests of the design. All sums are 32-bit, so nothing wraps.
    function automatic logic find_spot(input int need, output int where_w);
        int cand;
        int lim;
        int base;
        logic clash;
        where_w = 0;
        cand = 0;
        for (int i = 0; i < stfa_pkg::TOTAL_SLOTS; i++)
        begin
            if (shadow_size[i] != 0 && cand <= int'(shadow_off[i]))
                cand = int'(shadow_off[i]) + int'(shadow_size[i]);
        end
        if (cand + need <= int'(shadow_heap))
        begin
            where_w = cand;
            return 1'b1;
        end
        for (int i = 0; i < stfa_pkg::TOTAL_SLOTS; i++)
        begin
            lim  = int'(shadow_heap);
            base = int'(shadow_off[i]);
            for (int j = 0; j < stfa_pkg::TOTAL_SLOTS; j++)
            begin
                if (base < int'(shadow_off[j]) && int'(shadow_off[j]) < lim)
                    lim = int'(shadow_off[j]);
            end
            cand = base + int'(shadow_size[i]);
            if (cand + need <= lim)
            begin
                clash = 1'b0;
                for (int j = 0; j < stfa_pkg::TOTAL_SLOTS; j++)
                begin
                    // touching the start of a later block counts as overlap
                    if (cand + need >= int'(shadow_off[j]) &&
                        int'(shadow_off[j]) + int'(shadow_size[j]) > cand)
                        clash = 1'b1;
                end
                if (!clash)
                begin
                    where_w = cand;
                    return 1'b1;
                end
            end
        end
        return 1'b0;
    endfunction

    // Applies one request to the mirror and returns the result it must give.
    function automatic stfa_pkg::out_t predict_request(input stfa_pkg::in_t rq);
        stfa_pkg::out_t r;
        int   slot;
        int   spot;
        logic have;
        r    = '0;
        slot = 0;
        spot = 0;
        have = 1'b0;
        case (rq.req_type)
            stfa_pkg::REQ_ALLOC:
            begin
                if (rq.want_temp)
                begin
                    for (int i = stfa_pkg::TEMP_FIRST; i < stfa_pkg::VAR_SLOTS; i++)
                    begin
                        if (!have && shadow_size[i] == 0)
                        begin
                            slot = i;
                            have = 1'b1;
                        end
                    end
                end
                else if (rq.slot_index < stfa_pkg::TOTAL_SLOTS)
                begin
                    slot = rq.slot_index;
                    have = 1'b1;
                end
                if (!have)
                    r.status = stfa_pkg::ST_NO_TEMP;
                else if (find_spot(int'(rq.alloc_words), spot))
                begin
                    // an occupied target is simply overwritten
                    shadow_off[slot]   = spot[15:0];
                    shadow_size[slot]  = rq.alloc_words;
                    r.status           = stfa_pkg::ST_DONE;
                    r.block_offset_out = spot[15:0];
                    r.slot_used        = slot[SW-1:0];
                end
                else
                    r.status = stfa_pkg::ST_NO_MEM;
            end
            stfa_pkg::REQ_FREE:
            begin
                r.status = stfa_pkg::ST_NOT_FREED;
                if (rq.has_pointer)
                begin
                    // first offset match wins, even if that slot is already free
                    for (int i = 0; i < stfa_pkg::TOTAL_SLOTS; i++)
                    begin
                        if (r.status == stfa_pkg::ST_NOT_FREED &&
                            shadow_off[i] == rq.free_offset)
                        begin
                            shadow_size[i] = '0;
                            r.status       = stfa_pkg::ST_DONE;
                        end
                    end
                end
            end
            stfa_pkg::REQ_LINE:
            begin
                for (int i = stfa_pkg::TEMP_FIRST; i < stfa_pkg::VAR_SLOTS; i++)
                    shadow_size[i] = '0;
                r.status = stfa_pkg::ST_DONE;
            end
            default:
                r.status = stfa_pkg::ST_DONE;
        endcase
        return r;
    endfunction

    function automatic stfa_pkg::in_t make_item(input logic [1:0] kind, input int words,
                                                input logic temp, input int idx,
                                                input logic hasp, input int offs);
        stfa_pkg::in_t rq;
        rq.req_type    = kind;
        rq.alloc_words = words[15:0];
        rq.want_temp   = temp;
        rq.slot_index  = idx[SW-1:0];
        rq.has_pointer = hasp;
        rq.free_offset = offs[15:0];
        return rq;
    endfunction

    // Random request, biased toward well-formed traffic: sizes scaled to the
    // current heap and frees aimed at offsets that sit in the table right now.
    function automatic stfa_pkg::in_t make_request();
        stfa_pkg::in_t rq;
        int  roll;
        int  k;
        int  lim;
        rq.req_type    = 2'($urandom);
        rq.alloc_words = 16'($urandom);
        rq.want_temp   = 1'($urandom);
        rq.slot_index  = SW'($urandom);
        rq.has_pointer = 1'($urandom);
        rq.free_offset = 16'($urandom);
        roll = $urandom_range(99);
        lim  = (shadow_heap > 24) ? int'(shadow_heap) / 6 : 4;
        if (roll < 48)
        begin
            rq.req_type = stfa_pkg::REQ_ALLOC;
            if ($urandom_range(19) == 0)
                rq.slot_index = SW'($urandom_range(63, stfa_pkg::TOTAL_SLOTS));
            else
                rq.slot_index = SW'($urandom_range(stfa_pkg::TOTAL_SLOTS - 1));
            k = $urandom_range(9);
            if (k == 0)
                rq.alloc_words = '0;
            else if (k == 2)
                rq.alloc_words = 16'($urandom_range(int'(shadow_heap)));
            else if (k > 2)
                rq.alloc_words = 16'($urandom_range(lim, 1));
        end
        else if (roll < 78)
        begin
            rq.req_type    = stfa_pkg::REQ_FREE;
            rq.has_pointer = ($urandom_range(9) != 0);
            if ($urandom_range(3) != 0)
                rq.free_offset = shadow_off[$urandom_range(stfa_pkg::TOTAL_SLOTS - 1)];
        end
        else if (roll < 88)
            rq.req_type = stfa_pkg::REQ_LINE;
        else if (roll < 93)
            rq.req_type = stfa_pkg::REQ_NONE;
        return rq;
    endfunction

    // Sampled on the rising edge, where every testbench-driven input is stable.
    task automatic wait_idle();
        while (pend_q.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        // settle time after the last result before touching the register
        repeat (8) @(posedge clk);
    endtask

    task automatic write_heap(input logic [15:0] words);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_data  = words;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    // Request driver: a new transfer is offered once the previous one went
    // through, with random idle cycles in between. A stalled request is held.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            out_stall <= ($urandom_range(99) < recv_idle_pct);
            if (!in_valid || in_xfer)
            begin
                if (pend_q.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    in_data  <= pend_q.pop_front();
                    in_valid <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: result transfers are checked before the request taken at the
    // same edge is predicted, so the queue order matches the block's order.
    always @(posedge clk)
    begin
        if (!rst_n)
            in_xfer <= 1'b0;
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with no request pending",
                                    out_data.status, -1);
                else
                begin
                    due = expected_results.pop_front();
                    if (out_data.status !== due.status)
                        report_mismatch("status", out_data.status, due.status);
                    if (out_data.block_offset_out !== due.block_offset_out)
                        report_mismatch("block_offset_out", out_data.block_offset_out,
                                        due.block_offset_out);
                    if (out_data.slot_used !== due.slot_used)
                        report_mismatch("slot_used", out_data.slot_used, due.slot_used);
                end
            end
            if (in_valid && !in_stall)
                expected_results.push_back(predict_request(in_data));
            if (cfg_valid && cfg_ready)
                shadow_heap = cfg_data;
            in_xfer <= in_valid && !in_stall;
        end
    end

    // Watchdog: counts cycles with no transfer on any channel.
    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < HANG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin : stimulus
        int heap_sel;
        for (int i = 0; i < stfa_pkg::TOTAL_SLOTS; i++)
        begin
            shadow_off[i]  = '0;
            shadow_size[i] = '0;
        end
        shadow_heap   = '0;
        error_count   = 0;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        in_data       = '0;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        send_idle_pct = 15;
        recv_idle_pct = 55;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Empty heap: only a zero-size block fits; out-of-range slot indexes.
        write_heap(16'd0);
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 0, 1'b0, 0, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 1, 1'b1, 0, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 0, 1'b0, 63, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 0, 1'b0, stfa_pkg::TOTAL_SLOTS,
                                   1'b0, 0));
        wait_idle();

        // Small heap: fill it, overflow, open a hole and refill it by first fit,
        // overwrite a used slot, then the free corner cases and a no-op request.
        write_heap(16'd64);
        for (int i = 0; i < 4; i++)
            pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 16, 1'b0, i, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 8, 1'b0, stfa_pkg::TOTAL_SLOTS - 1,
                                   1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_FREE, 0, 1'b0, 0, 1'b1, 16));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 8, 1'b0, 5, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 4, 1'b0, 0, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_FREE, 0, 1'b0, 0, 1'b1, 16'hBEEF));
        pend_q.push_back(make_item(stfa_pkg::REQ_FREE, 0, 1'b0, 0, 1'b0, 32));
        pend_q.push_back(make_item(stfa_pkg::REQ_NONE, 16'hFFFF, 1'b1, 63, 1'b1, 16'hFFFF));
        wait_idle();

        // Full-size heap: run out of temporary slots, line start releases them,
        // a maximum-size request, and a free that hits an already free slot.
        write_heap(16'hFFFF);
        for (int i = 0; i <= stfa_pkg::VAR_SLOTS - stfa_pkg::TEMP_FIRST; i++)
            pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 1, 1'b1, 0, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_LINE, 0, 1'b0, 0, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_ALLOC, 16'hFFFF, 1'b1, 0, 1'b0, 0));
        pend_q.push_back(make_item(stfa_pkg::REQ_FREE, 0, 1'b0, 0, 1'b1, 0));

        // Random phases: two with sender idling lightly and receiver heavily,
        // two the other way round, two with no idling; heap size changes per phase.
        for (int p = 0; p < 6; p++)
        begin
            wait_idle();
            send_idle_pct = (p < 2) ? 15 : (p < 4) ? 55 : 0;
            recv_idle_pct = (p < 2) ? 55 : (p < 4) ? 15 : 0;
            heap_sel = p;
            case (heap_sel)
                0:       write_heap(16'd96);
                1:       write_heap(16'hFFFF);
                2:       write_heap(16'd40);
                3:       write_heap(16'd700);
                4:       write_heap(16'd0);
                default: write_heap(16'd220);
            endcase
            repeat (PHASE_ITEMS)
            begin
                // generate just ahead of the driver so frees see a fresh table
                while (pend_q.size() >= 2)
                    @(posedge clk);
                pend_q.push_back(make_request());
            end
        end
        wait_idle();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

`default_nettype wire
